@@ sv/ssl_pkg.sv @@
package ssl_pkg;

   localparam int SERVO_COUNT = 12;
   localparam int IDX_W = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
   localparam logic [7:0] ANGLE_FULL = 8'd180;
   localparam logic [7:0] SERVO_LIMIT = 8'(SERVO_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SERVO_COUNT - 1);

   // floor(n / 180) == (n * RECIP_MULT) >> RECIP_SHIFT for n < 2**20
   localparam int RECIP_SHIFT = 28;
   localparam logic [20:0] RECIP_MULT = 21'd1491309;

   localparam logic [7:0]  STEP_SIZE_RESET    = 8'd2;
   localparam logic [11:0] DUTY_AT_ZERO_RESET = 12'd150;
   localparam logic [11:0] DUTY_AT_FULL_RESET = 12'd600;

   typedef enum logic {
      REQ_SET_TARGET = 1'b0,
      REQ_TICK       = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_STEP_SIZE    = 2'd0,
      CSR_DUTY_AT_ZERO = 2'd1,
      CSR_DUTY_AT_FULL = 2'd2
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_TICK
   } state_type;

   typedef struct packed {
      logic [7:0]  step_size;
      logic [11:0] duty_at_zero;
      logic [11:0] duty_at_full;
   } cfg_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
      logic             last;
   } issue_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      logic [7:0]       data;
   } wb_type;

endpackage

@@ sv/ssl_store.sv @@
module ssl_store (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [ssl_pkg::IDX_W-1:0] rd_addr,
   input  ssl_pkg::wb_type           pos_wr,
   input  ssl_pkg::wb_type           tgt_wr,
   output logic [7:0]                rd_pos,
   output logic [7:0]                rd_tgt
);

   logic [7:0] pos_mem_ff [ssl_pkg::SERVO_COUNT];
   logic [7:0] tgt_mem_ff [ssl_pkg::SERVO_COUNT];
   logic [ssl_pkg::SERVO_COUNT-1:0] pos_vld_ff, pos_vld_in;
   logic [ssl_pkg::SERVO_COUNT-1:0] tgt_vld_ff, tgt_vld_in;
   logic [7:0] rd_pos_ff;
   logic [7:0] rd_tgt_ff;

   always_comb begin
      pos_vld_in = pos_vld_ff;
      tgt_vld_in = tgt_vld_ff;
      if (pos_wr.en) begin
         pos_vld_in[pos_wr.addr] = 1'b1;
      end
      if (tgt_wr.en) begin
         tgt_vld_in[tgt_wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_vld_ff <= '0;
         tgt_vld_ff <= '0;
      end else begin
         pos_vld_ff <= pos_vld_in;
         tgt_vld_ff <= tgt_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pos_wr.en) begin
         pos_mem_ff[pos_wr.addr] <= pos_wr.data;
      end
      if (tgt_wr.en) begin
         tgt_mem_ff[tgt_wr.addr] <= tgt_wr.data;
      end
      if (rd_en) begin
         rd_pos_ff <= pos_vld_ff[rd_addr] ? pos_mem_ff[rd_addr] : 8'd0;
         rd_tgt_ff <= tgt_vld_ff[rd_addr] ? tgt_mem_ff[rd_addr] : 8'd0;
      end
   end

   assign rd_pos = rd_pos_ff;
   assign rd_tgt = rd_tgt_ff;

endmodule

@@ sv/ssl_ramp.sv @@
module ssl_ramp (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  ssl_pkg::issue_type  issue,
   input  ssl_pkg::cfg_type    cfg,
   input  logic [7:0]          rd_pos,
   input  logic [7:0]          rd_tgt,
   output ssl_pkg::wb_type     pos_wr,
   output logic                s1_busy,
   output logic                out_valid,
   output logic [4:0]          out_number,
   output logic [11:0]         out_duty,
   output logic [7:0]          out_position,
   output logic                out_at_target,
   output logic                out_last
);

   // stage 1: memory data, slew step, span product
   logic                      v1_ff;
   logic [ssl_pkg::IDX_W-1:0] idx1_ff;
   logic                      last1_ff;
   logic [7:0]                new_pos;
   logic [7:0]                diff;
   logic                      span_neg;
   logic [11:0]               span_mag;
   logic [19:0]               prod;

   // stage 2: reciprocal multiply
   logic                      v2_ff;
   logic [ssl_pkg::IDX_W-1:0] idx2_ff;
   logic                      last2_ff;
   logic [7:0]                pos2_ff;
   logic                      at2_ff;
   logic [19:0]               prod2_ff;
   logic                      neg2_ff;
   logic [40:0]               wide;
   logic [11:0]               quot;
   logic [11:0]               duty;

   // output register
   logic                      out_valid_ff;
   logic [4:0]                out_number_ff;
   logic [11:0]               out_duty_ff;
   logic [7:0]                out_position_ff;
   logic                      out_at_target_ff;
   logic                      out_last_ff;

   always_comb begin
      new_pos = rd_pos;
      diff    = 8'd0;
      if (rd_pos < rd_tgt) begin
         diff    = rd_tgt - rd_pos;
         new_pos = (diff > cfg.step_size) ? rd_pos + cfg.step_size : rd_tgt;
      end else if (rd_pos > rd_tgt) begin
         diff    = rd_pos - rd_tgt;
         new_pos = (diff > cfg.step_size) ? rd_pos - cfg.step_size : rd_tgt;
      end
      span_neg = cfg.duty_at_full < cfg.duty_at_zero;
      span_mag = span_neg ? cfg.duty_at_zero - cfg.duty_at_full
                          : cfg.duty_at_full - cfg.duty_at_zero;
      prod     = 20'(new_pos) * 20'(span_mag);
   end

   assign pos_wr.en   = en && v1_ff;
   assign pos_wr.addr = idx1_ff;
   assign pos_wr.data = new_pos;
   assign s1_busy     = v1_ff;

   always_comb begin
      wide = 41'(prod2_ff) * 41'(ssl_pkg::RECIP_MULT);
      quot = wide[ssl_pkg::RECIP_SHIFT +: 12];
      duty = neg2_ff ? cfg.duty_at_zero - quot : cfg.duty_at_zero + quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= issue.valid;
         v2_ff        <= v1_ff;
         out_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         idx1_ff          <= issue.idx;
         last1_ff         <= issue.last;
         idx2_ff          <= idx1_ff;
         last2_ff         <= last1_ff;
         pos2_ff          <= new_pos;
         at2_ff           <= new_pos == rd_tgt;
         prod2_ff         <= prod;
         neg2_ff          <= span_neg;
         out_number_ff    <= 5'(idx2_ff);
         out_duty_ff      <= duty;
         out_position_ff  <= pos2_ff;
         out_at_target_ff <= at2_ff;
         out_last_ff      <= last2_ff;
      end
   end

   assign out_valid     = out_valid_ff;
   assign out_number    = out_number_ff;
   assign out_duty      = out_duty_ff;
   assign out_position  = out_position_ff;
   assign out_at_target = out_at_target_ff;
   assign out_last      = out_last_ff;

endmodule

@@ sv/servo_slew_limiter_bank.sv @@
// set-target transaction: no result
// tick transaction: results pass stage 1, stage 2 and the output register, then one result per cycle
// while rsp_tready is high, SERVO_COUNT results in all; the stage-1 write-back of the
// position store paces the next tick, which is taken only once stage 1 is empty
// reset (synchronous, active high) clears control state and the store valid bits,
// so every position and target reads as zero; registers return to defaults
module servo_slew_limiter_bank (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // servo_index, target_angle
   input  logic        req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // servo_number, duty, position, at_target, zero pad
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wdata
);

   ssl_pkg::state_type        state_ff, state_in;
   logic [ssl_pkg::IDX_W-1:0] cnt_ff, cnt_in;
   ssl_pkg::cfg_type          cfg_ff, cfg_in;
   ssl_pkg::issue_type        issue;
   ssl_pkg::wb_type           pos_wr;
   ssl_pkg::wb_type           tgt_wr;
   logic                      en;
   logic                      accept;
   logic                      s1_busy;
   logic [7:0]                rd_pos;
   logic [7:0]                rd_tgt;
   logic [7:0]                req_index;
   logic [7:0]                req_angle;
   logic [4:0]                out_number;
   logic [11:0]               out_duty;
   logic [7:0]                out_position;
   logic                      out_at_target;

   assign req_index = req_tdata[7:0];
   assign req_angle = req_tdata[15:8];
   assign en        = !rsp_tvalid || rsp_tready;
   assign accept    = req_tvalid && req_tready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            ssl_pkg::CSR_STEP_SIZE:    cfg_in.step_size    = csr_wdata[7:0];
            ssl_pkg::CSR_DUTY_AT_ZERO: cfg_in.duty_at_zero = csr_wdata;
            ssl_pkg::CSR_DUTY_AT_FULL: cfg_in.duty_at_full = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      req_tready  = 1'b0;
      issue.valid = 1'b0;
      issue.idx   = cnt_ff;
      issue.last  = cnt_ff == ssl_pkg::LAST_IDX;
      tgt_wr.en   = 1'b0;
      tgt_wr.addr = req_index[ssl_pkg::IDX_W-1:0];
      tgt_wr.data = (req_angle > ssl_pkg::ANGLE_FULL) ? ssl_pkg::ANGLE_FULL : req_angle;
      unique case (state_ff)
         ssl_pkg::ST_IDLE: begin
            req_tready = !s1_busy;
            if (accept) begin
               if (req_tuser == ssl_pkg::REQ_TICK) begin
                  state_in = ssl_pkg::ST_TICK;
                  cnt_in   = '0;
               end else begin
                  tgt_wr.en = req_index < ssl_pkg::SERVO_LIMIT;
               end
            end
         end
         ssl_pkg::ST_TICK: begin
            issue.valid = 1'b1;
            if (en) begin
               if (cnt_ff == ssl_pkg::LAST_IDX) begin
                  state_in = ssl_pkg::ST_IDLE;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         default: state_in = ssl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff            <= ssl_pkg::ST_IDLE;
         cnt_ff              <= '0;
         cfg_ff.step_size    <= ssl_pkg::STEP_SIZE_RESET;
         cfg_ff.duty_at_zero <= ssl_pkg::DUTY_AT_ZERO_RESET;
         cfg_ff.duty_at_full <= ssl_pkg::DUTY_AT_FULL_RESET;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         cfg_ff   <= cfg_in;
      end
   end

   ssl_store u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (en),
      .rd_addr (cnt_ff),
      .pos_wr  (pos_wr),
      .tgt_wr  (tgt_wr),
      .rd_pos  (rd_pos),
      .rd_tgt  (rd_tgt)
   );

   ssl_ramp u_ramp (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .issue         (issue),
      .cfg           (cfg_ff),
      .rd_pos        (rd_pos),
      .rd_tgt        (rd_tgt),
      .pos_wr        (pos_wr),
      .s1_busy       (s1_busy),
      .out_valid     (rsp_tvalid),
      .out_number    (out_number),
      .out_duty      (out_duty),
      .out_position  (out_position),
      .out_at_target (out_at_target),
      .out_last      (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, out_at_target, out_position, out_duty, out_number};

endmodule

@@ sv/ssl_checker.sv @@
module ssl_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result dropped or changed under stall");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[24:17] <= ssl_pkg::ANGLE_FULL)
      else $error("position beyond full angle");

   a_last_number: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == (rsp_tdata[4:0] == 5'(ssl_pkg::SERVO_COUNT - 1)))
      else $error("last flag does not match final servo");

endmodule

bind servo_slew_limiter_bank ssl_checker u_ssl_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

@@ bench/servo_slew_limiter_bank_test.sv @@
module servo_slew_limiter_bank_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int HOLD_CYCLES    = 400;
   localparam int TICK_PERCENT   = 35;

   typedef enum {
      SINK_ALWAYS,
      SINK_RANDOM,
      SINK_PATTERN
   } sink_mode_type;

   typedef struct packed {
      logic [4:0]  servo_number;
      logic [11:0] duty;
      logic [7:0]  position;
      logic        at_target;
      logic        last;
   } servo_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = ssl_pkg::CSR_STEP_SIZE;
   logic [11:0] csr_wdata = '0;

   // slew limiter state as the bench sees it
   logic [7:0]       servo_position [ssl_pkg::SERVO_COUNT];
   logic [7:0]       aim_angle [ssl_pkg::SERVO_COUNT];
   ssl_pkg::cfg_type limiter_cfg;

   servo_report_type pending_reports [$];

   int            error_count = 0;
   int            idle_cycles = 0;
   int            burst_left = 0;
   int            gap_limit = 4;
   int            hold_left = 0;
   int            stall_phase = 0;
   sink_mode_type sink_mode = SINK_ALWAYS;

   servo_slew_limiter_bank uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      for (int i = 0; i < ssl_pkg::SERVO_COUNT; i++) begin
         servo_position[i] = '0;
         aim_angle[i] = '0;
      end
      limiter_cfg.step_size = ssl_pkg::STEP_SIZE_RESET;
      limiter_cfg.duty_at_zero = ssl_pkg::DUTY_AT_ZERO_RESET;
      limiter_cfg.duty_at_full = ssl_pkg::DUTY_AT_FULL_RESET;
   end

   // applies one accepted transaction and queues the reports of a tick
   task automatic advance_servos(ssl_pkg::req_kind_type kind, logic [7:0] index,
                                 logic [7:0] angle);
      servo_report_type report;
      logic [7:0] pos;
      logic [7:0] tgt;
      int span;
      int scaled;
      if (kind == ssl_pkg::REQ_SET_TARGET) begin
         if (index < ssl_pkg::SERVO_LIMIT)
            aim_angle[index] = (angle > ssl_pkg::ANGLE_FULL) ? ssl_pkg::ANGLE_FULL : angle;
         return;
      end
      span = int'(limiter_cfg.duty_at_full) - int'(limiter_cfg.duty_at_zero);
      for (int i = 0; i < ssl_pkg::SERVO_COUNT; i++) begin
         pos = servo_position[i];
         tgt = aim_angle[i];
         if (pos < tgt)
            pos = (tgt - pos > limiter_cfg.step_size) ? pos + limiter_cfg.step_size : tgt;
         else if (pos > tgt)
            pos = (pos - tgt > limiter_cfg.step_size) ? pos - limiter_cfg.step_size : tgt;
         servo_position[i] = pos;
         scaled = (int'(pos) * span) / int'(ssl_pkg::ANGLE_FULL);
         report.servo_number = 5'(i);
         report.duty = 12'(int'(limiter_cfg.duty_at_zero) + scaled);
         report.position = pos;
         report.at_target = (pos == tgt);
         report.last = (i == ssl_pkg::SERVO_COUNT - 1);
         pending_reports.push_back(report);
      end
   endtask

   task automatic send_item(ssl_pkg::req_kind_type kind, logic [7:0] index,
                            logic [7:0] angle);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         gap = $urandom_range(0, gap_limit);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = {angle, index};
      do @(posedge clock); while (!req_tready);
      advance_servos(kind, index, angle);
   endtask

   task automatic send_random_item();
      int roll;
      logic [7:0] index;
      logic [7:0] angle;
      roll = $urandom_range(0, 99);
      if (roll < TICK_PERCENT) begin
         send_item(ssl_pkg::REQ_TICK, 8'($urandom), 8'($urandom));
      end else begin
         index = (roll % 10 == 0) ? 8'($urandom)
                                  : 8'($urandom_range(0, ssl_pkg::SERVO_COUNT - 1));
         angle = (roll % 7 == 0) ? 8'($urandom_range(181, 255)) : 8'($urandom_range(0, 180));
         send_item(ssl_pkg::REQ_SET_TARGET, index, angle);
      end
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(ssl_pkg::csr_index_type index, logic [11:0] value);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      case (index)
         ssl_pkg::CSR_STEP_SIZE: limiter_cfg.step_size = value[7:0];
         ssl_pkg::CSR_DUTY_AT_ZERO: limiter_cfg.duty_at_zero = value;
         ssl_pkg::CSR_DUTY_AT_FULL: limiter_cfg.duty_at_full = value;
         default: ;
      endcase
   endtask

   task automatic test_reset_state();
      send_item(ssl_pkg::REQ_TICK, 8'h00, 8'h00);
   endtask

   task automatic test_target_limits();
      send_item(ssl_pkg::REQ_SET_TARGET, 8'd0, 8'd255);
      send_item(ssl_pkg::REQ_SET_TARGET, 8'(ssl_pkg::SERVO_COUNT - 1), 8'd180);
      send_item(ssl_pkg::REQ_SET_TARGET, 8'd5, 8'd181);
      send_item(ssl_pkg::REQ_SET_TARGET, 8'd3, 8'd1);
      send_item(ssl_pkg::REQ_SET_TARGET, ssl_pkg::SERVO_LIMIT, 8'd77);
      send_item(ssl_pkg::REQ_SET_TARGET, 8'd255, 8'd255);
      send_item(ssl_pkg::REQ_SET_TARGET, 8'd7, 8'd128);
      send_item(ssl_pkg::REQ_TICK, 8'hff, 8'hff);
      send_item(ssl_pkg::REQ_TICK, 8'h00, 8'h00);
   endtask

   task automatic test_step_extremes();
      wait_for_drain();
      write_register(ssl_pkg::CSR_STEP_SIZE, 12'd180);
      send_item(ssl_pkg::REQ_SET_TARGET, 8'd1, 8'd90);
      send_item(ssl_pkg::REQ_TICK, 8'h00, 8'h00);
      wait_for_drain();
      write_register(ssl_pkg::CSR_STEP_SIZE, 12'd0);
      send_item(ssl_pkg::REQ_SET_TARGET, 8'd0, 8'd0);
      send_item(ssl_pkg::REQ_TICK, 8'h00, 8'h00);
      wait_for_drain();
      write_register(ssl_pkg::CSR_STEP_SIZE, 12'd255);
      send_item(ssl_pkg::REQ_SET_TARGET, 8'd2, 8'd180);
      send_item(ssl_pkg::REQ_TICK, 8'h00, 8'h00);
      wait_for_drain();
      write_register(ssl_pkg::CSR_STEP_SIZE, 12'd1);
      send_item(ssl_pkg::REQ_SET_TARGET, 8'(ssl_pkg::SERVO_COUNT - 1), 8'd0);
      send_item(ssl_pkg::REQ_TICK, 8'h00, 8'h00);
   endtask

   task automatic test_duty_endpoints();
      wait_for_drain();
      write_register(ssl_pkg::CSR_DUTY_AT_ZERO, 12'd4095);
      write_register(ssl_pkg::CSR_DUTY_AT_FULL, 12'd0);
      send_item(ssl_pkg::REQ_TICK, 8'h00, 8'h00);
      wait_for_drain();
      write_register(ssl_pkg::CSR_DUTY_AT_ZERO, 12'd0);
      write_register(ssl_pkg::CSR_DUTY_AT_FULL, 12'd4095);
      send_item(ssl_pkg::REQ_SET_TARGET, 8'd4, 8'd97);
      send_item(ssl_pkg::REQ_TICK, 8'h00, 8'h00);
      wait_for_drain();
      write_register(ssl_pkg::CSR_DUTY_AT_ZERO, 12'd4095);
      write_register(ssl_pkg::CSR_DUTY_AT_FULL, 12'd4095);
      send_item(ssl_pkg::REQ_TICK, 8'h00, 8'h00);
   endtask

   task automatic test_random_settings();
      for (int phase = 0; phase < 6; phase++) begin
         wait_for_drain();
         case (phase)
            0: begin
               write_register(ssl_pkg::CSR_STEP_SIZE, 12'd1);
               write_register(ssl_pkg::CSR_DUTY_AT_ZERO, 12'd0);
               write_register(ssl_pkg::CSR_DUTY_AT_FULL, 12'd4095);
            end
            1: begin
               write_register(ssl_pkg::CSR_STEP_SIZE, 12'd180);
               write_register(ssl_pkg::CSR_DUTY_AT_ZERO, 12'd4095);
               write_register(ssl_pkg::CSR_DUTY_AT_FULL, 12'd0);
            end
            default: begin
               write_register(ssl_pkg::CSR_STEP_SIZE, 12'($urandom_range(1, 12)));
               write_register(ssl_pkg::CSR_DUTY_AT_ZERO, 12'($urandom));
               write_register(ssl_pkg::CSR_DUTY_AT_FULL, 12'($urandom));
            end
         endcase
         sink_mode = sink_mode_type'(phase % 3);
         gap_limit = (phase == 0) ? 0 : $urandom_range(2, 8);
         repeat (68) send_random_item();
      end
   endtask

   task automatic test_output_backpressure();
      wait_for_drain();
      sink_mode = SINK_ALWAYS;
      gap_limit = 0;
      @(negedge clock);
      hold_left = HOLD_CYCLES;
      repeat (30) begin
         if ($urandom_range(0, 3) == 0)
            send_item(ssl_pkg::REQ_SET_TARGET,
                      8'($urandom_range(0, ssl_pkg::SERVO_COUNT - 1)), 8'($urandom));
         else
            send_item(ssl_pkg::REQ_TICK, 8'($urandom), 8'($urandom));
      end
      gap_limit = 4;
   endtask

   // result side ready pattern
   always @(negedge clock) begin
      stall_phase++;
      if (hold_left > 0) begin
         rsp_tready = 1'b0;
         hold_left--;
      end else begin
         case (sink_mode)
            SINK_ALWAYS: rsp_tready = 1'b1;
            SINK_RANDOM: rsp_tready = ($urandom_range(0, 3) != 0);
            default: rsp_tready = (stall_phase % 7 > 2) || (stall_phase % 19 == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      servo_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected result transaction: rsp_tdata %h", rsp_tdata);
            error_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_tdata[4:0] !== want.servo_number) begin
               $error("servo_number: expected %0d, actual %0d", want.servo_number,
                      rsp_tdata[4:0]);
               error_count++;
            end
            if (rsp_tdata[16:5] !== want.duty) begin
               $error("duty: expected %0d, actual %0d", want.duty, rsp_tdata[16:5]);
               error_count++;
            end
            if (rsp_tdata[24:17] !== want.position) begin
               $error("position: expected %0d, actual %0d", want.position, rsp_tdata[24:17]);
               error_count++;
            end
            if (rsp_tdata[25] !== want.at_target) begin
               $error("at_target: expected %0d, actual %0d", want.at_target, rsp_tdata[25]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_state();
      test_target_limits();
      test_step_extremes();
      test_duty_endpoints();
      test_random_settings();
      test_output_backpressure();
      wait_for_drain();
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
